/* rtl/tsp_pkg.sv */
// shared types, constants and decode functions for the utc timestamp parser
// no dependencies; used by every rtl file of the block
package tsp_pkg;

  localparam int unsigned TsLength = 20;

  localparam logic [2:0] STAT_OK        = 3'd0;
  localparam logic [2:0] STAT_LENGTH    = 3'd1;
  localparam logic [2:0] STAT_SEPARATOR = 3'd2;
  localparam logic [2:0] STAT_DIGIT     = 3'd3;
  localparam logic [2:0] STAT_RANGE     = 3'd4;

  localparam logic [7:0] CH_NONE  = 8'h00;
  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_T     = 8'h54;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_Z     = 8'h5A;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  localparam logic [13:0] YEAR_MIN    = 14'd2024;
  localparam logic [13:0] YEAR_MAX    = 14'd2099;
  localparam logic [13:0] YEAR_EPOCH  = 14'd1970;
  localparam logic [6:0]  MONTH_MAX   = 7'd12;
  localparam logic [6:0]  DAY_MAX     = 7'd31;
  localparam logic [6:0]  HOUR_MAX    = 7'd23;
  localparam logic [6:0]  MINSEC_MAX  = 7'd59;
  localparam logic [16:0] LEAP_OFFSET = 17'd492;
  localparam logic [31:0] EPOCH_FLOOR = 32'd1700000000;

  typedef enum logic [2:0] {
    ST_SCAN,
    ST_DAYS,
    ST_TOD,
    ST_EPOCH,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic take;
    logic calc_days;
    logic calc_tod;
    logic calc_epoch;
    logic clear;
  } cmd_t;

  // expected separator at a string position, CH_NONE for digit positions
  function automatic logic [7:0] sep_char(input logic [4:0] pos);
    logic [7:0] ch;
    unique case (pos) inside
      5'd4, 5'd7:   ch = CH_DASH;
      5'd10:        ch = CH_T;
      5'd13, 5'd16: ch = CH_COLON;
      5'd19:        ch = CH_Z;
      default:      ch = CH_NONE;
    endcase
    return ch;
  endfunction

  function automatic logic [8:0] days_before_month(input logic [3:0] midx);
    logic [8:0] d;
    unique case (midx)
      4'd0:    d = 9'd0;
      4'd1:    d = 9'd31;
      4'd2:    d = 9'd59;
      4'd3:    d = 9'd90;
      4'd4:    d = 9'd120;
      4'd5:    d = 9'd151;
      4'd6:    d = 9'd181;
      4'd7:    d = 9'd212;
      4'd8:    d = 9'd243;
      4'd9:    d = 9'd273;
      4'd10:   d = 9'd304;
      4'd11:   d = 9'd334;
      default: d = 9'd0;
    endcase
    return d;
  endfunction

endpackage

/* rtl/tsp_ctrl.sv */
// sequencer of the timestamp parser: scan, three epoch steps, result hold
// depends on tsp_pkg
module tsp_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  logic           in_last_char,
  input  logic           out_stall,
  output logic           in_stall,
  output logic           out_valid,
  output tsp_pkg::cmd_t  cmd
);

  tsp_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tsp_pkg::ST_SCAN;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    out_valid = 1'b0;
    unique case (state_r)
      tsp_pkg::ST_SCAN: begin
        in_stall = 1'b0;
        cmd.take = in_valid;
        if (in_valid && in_last_char) begin
          state_nxt = tsp_pkg::ST_DAYS;
        end
      end
      tsp_pkg::ST_DAYS: begin
        cmd.calc_days = 1'b1;
        state_nxt     = tsp_pkg::ST_TOD;
      end
      tsp_pkg::ST_TOD: begin
        cmd.calc_tod = 1'b1;
        state_nxt    = tsp_pkg::ST_EPOCH;
      end
      tsp_pkg::ST_EPOCH: begin
        cmd.calc_epoch = 1'b1;
        state_nxt      = tsp_pkg::ST_OUT;
      end
      tsp_pkg::ST_OUT: begin
        out_valid = 1'b1;
        if (!out_stall) begin
          cmd.clear = 1'b1;
          state_nxt = tsp_pkg::ST_SCAN;
        end
      end
      default: state_nxt = tsp_pkg::ST_SCAN;
    endcase
  end

endmodule

/* rtl/tsp_dp.sv */
// datapath of the timestamp parser: position, field accumulators, checks, epoch
// depends on tsp_pkg; driven by tsp_ctrl commands
module tsp_dp (
  input  logic           clk,
  input  logic           rst_n,
  input  tsp_pkg::cmd_t  cmd,
  input  logic [7:0]     character,
  output logic [2:0]     status,
  output logic [13:0]    year,
  output logic [6:0]     month,
  output logic [6:0]     day,
  output logic [6:0]     hour,
  output logic [6:0]     minute,
  output logic [6:0]     second,
  output logic [31:0]    epoch_seconds
);

  logic [4:0]  pos_r, pos_nxt;
  logic [13:0] year_r, year_nxt;
  logic [6:0]  month_r, month_nxt;
  logic [6:0]  day_r, day_nxt;
  logic [6:0]  hour_r, hour_nxt;
  logic [6:0]  minute_r, minute_nxt;
  logic [6:0]  second_r, second_nxt;
  logic [2:0]  err_r, err_nxt;

  logic [2:0]  status_r;
  logic [15:0] days_r;
  logic [16:0] tod_r;
  logic [31:0] epoch_r;

  logic        is_digit;
  logic [3:0]  digit;
  logic [7:0]  want;
  logic [2:0]  new_err;

  assign is_digit = (character >= tsp_pkg::CH_ZERO) && (character <= tsp_pkg::CH_NINE);
  assign digit    = 4'(character - tsp_pkg::CH_ZERO);
  assign want     = tsp_pkg::sep_char(pos_r);

  always_comb begin
    pos_nxt    = pos_r;
    year_nxt   = year_r;
    month_nxt  = month_r;
    day_nxt    = day_r;
    hour_nxt   = hour_r;
    minute_nxt = minute_r;
    second_nxt = second_r;
    err_nxt    = err_r;
    new_err    = tsp_pkg::STAT_OK;
    if (cmd.clear) begin
      pos_nxt    = '0;
      year_nxt   = '0;
      month_nxt  = '0;
      day_nxt    = '0;
      hour_nxt   = '0;
      minute_nxt = '0;
      second_nxt = '0;
      err_nxt    = tsp_pkg::STAT_OK;
    end else if (cmd.take) begin
      if (pos_r < 5'(tsp_pkg::TsLength)) begin
        if (want != tsp_pkg::CH_NONE) begin
          if (character != want) begin
            new_err = tsp_pkg::STAT_SEPARATOR;
          end
        end else if (!is_digit) begin
          new_err = tsp_pkg::STAT_DIGIT;
        end else if (pos_r <= 5'd3) begin
          year_nxt = 14'(year_r * 14'd10 + 14'(digit));
        end else if (pos_r <= 5'd6) begin
          month_nxt = 7'(month_r * 7'd10 + 7'(digit));
        end else if (pos_r <= 5'd9) begin
          day_nxt = 7'(day_r * 7'd10 + 7'(digit));
        end else if (pos_r <= 5'd12) begin
          hour_nxt = 7'(hour_r * 7'd10 + 7'(digit));
        end else if (pos_r <= 5'd15) begin
          minute_nxt = 7'(minute_r * 7'd10 + 7'(digit));
        end else begin
          second_nxt = 7'(second_r * 7'd10 + 7'(digit));
        end
      end
      // keep the lowest nonzero code: separator wins over non-digit
      if (new_err != tsp_pkg::STAT_OK &&
          (err_r == tsp_pkg::STAT_OK || new_err < err_r)) begin
        err_nxt = new_err;
      end
      if (pos_r != 5'd31) begin
        pos_nxt = pos_r + 5'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r    <= '0;
      year_r   <= '0;
      month_r  <= '0;
      day_r    <= '0;
      hour_r   <= '0;
      minute_r <= '0;
      second_r <= '0;
      err_r    <= tsp_pkg::STAT_OK;
    end else begin
      pos_r    <= pos_nxt;
      year_r   <= year_nxt;
      month_r  <= month_nxt;
      day_r    <= day_nxt;
      hour_r   <= hour_nxt;
      minute_r <= minute_nxt;
      second_r <= second_nxt;
      err_r    <= err_nxt;
    end
  end

  // epoch steps: day count and status, time of day, then the final sum
  logic        range_bad;
  logic [2:0]  status_nxt;
  logic [16:0] days_nxt;
  logic [3:0]  midx;
  logic        leap_add;
  logic [16:0] tod_nxt;
  logic [31:0] epoch_sum;

  assign range_bad = (year_r < tsp_pkg::YEAR_MIN) || (year_r > tsp_pkg::YEAR_MAX) ||
                     (month_r == 7'd0) || (month_r > tsp_pkg::MONTH_MAX) ||
                     (day_r == 7'd0) || (day_r > tsp_pkg::DAY_MAX) ||
                     (hour_r > tsp_pkg::HOUR_MAX) || (minute_r > tsp_pkg::MINSEC_MAX) ||
                     (second_r > tsp_pkg::MINSEC_MAX);

  always_comb begin
    if (pos_r != 5'(tsp_pkg::TsLength)) begin
      status_nxt = tsp_pkg::STAT_LENGTH;
    end else if (err_r != tsp_pkg::STAT_OK) begin
      status_nxt = err_r;
    end else if (range_bad) begin
      status_nxt = tsp_pkg::STAT_RANGE;
    end else begin
      status_nxt = tsp_pkg::STAT_OK;
    end
  end

  assign midx     = 4'(month_r - 7'd1);
  assign leap_add = (year_r[1:0] == 2'b00) && (month_r > 7'd2);
  assign days_nxt = 17'(8'(year_r - tsp_pkg::YEAR_EPOCH) * 17'd365)
                  + 17'((year_r - 14'd1) >> 2) - tsp_pkg::LEAP_OFFSET
                  + 17'(tsp_pkg::days_before_month(midx)) + 17'(leap_add)
                  + 17'(day_r) - 17'd1;
  assign tod_nxt  = 17'(hour_r * 17'd3600) + 17'(minute_r * 17'd60) + 17'(second_r);
  assign epoch_sum = 32'(days_r * 32'd86400) + 32'(tod_r);

  always_ff @(posedge clk) begin
    if (cmd.calc_days) begin
      status_r <= status_nxt;
      days_r   <= 16'(days_nxt);
    end else if (cmd.calc_epoch) begin
      if (status_r == tsp_pkg::STAT_OK && epoch_sum >= tsp_pkg::EPOCH_FLOOR) begin
        epoch_r <= epoch_sum;
      end else begin
        epoch_r <= '0;
        if (status_r == tsp_pkg::STAT_OK) begin
          status_r <= tsp_pkg::STAT_RANGE;
        end
      end
    end
    if (cmd.calc_tod) begin
      tod_r <= tod_nxt;
    end
  end

  assign status        = status_r;
  assign year          = year_r;
  assign month         = month_r;
  assign day           = day_r;
  assign hour          = hour_r;
  assign minute        = minute_r;
  assign second        = second_r;
  assign epoch_seconds = epoch_r;

endmodule

/* rtl/iso8601_timestamp_parser.sv */
// top level of the utc timestamp parser (YYYY-MM-DDTHH:MM:SSZ to epoch seconds)
// depends on tsp_pkg, tsp_ctrl and tsp_dp
//
// usage:
//   the input channel (in_valid, in_stall, in_character, in_last_char) takes one
//   byte of the string per item, first byte first; in_last_char marks the end.
//   while a string is being scanned in_stall is low, so one byte enters per cycle.
//   after the marked byte is accepted, in_stall goes high and the block works
//   out the epoch in order: day count and status, time of day, then
//   days * 86400 plus time of day (constant multipliers; time of day uses two).
//   the result item appears on out_* once ST_DAYS, ST_TOD and ST_EPOCH have
//   run, and holds until taken (out_valid high, out_stall low).
//   the cycle after the take, in_stall drops and the next string may start.
//   a new string is not accepted until the result of the last one is taken;
//   out_status reports ok, wrong length, bad separator,
//   non-digit or out of range, and out_epoch_seconds is zero unless ok.
//   the six field outputs show the accumulated digits even on error.
//   reset (rst_n low, synchronous) clears position, accumulators and error and
//   returns the sequencer to scanning with no result pending.
module iso8601_timestamp_parser (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_character,
  input  logic        in_last_char,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_status,
  output logic [13:0] out_year,
  output logic [6:0]  out_month,
  output logic [6:0]  out_day,
  output logic [6:0]  out_hour,
  output logic [6:0]  out_minute,
  output logic [6:0]  out_second,
  output logic [31:0] out_epoch_seconds
);

  tsp_pkg::cmd_t cmd;

  tsp_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_last_char (in_last_char),
    .out_stall    (out_stall),
    .in_stall     (in_stall),
    .out_valid    (out_valid),
    .cmd          (cmd)
  );

  tsp_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .character     (in_character),
    .status        (out_status),
    .year          (out_year),
    .month         (out_month),
    .day           (out_day),
    .hour          (out_hour),
    .minute        (out_minute),
    .second        (out_second),
    .epoch_seconds (out_epoch_seconds)
  );

endmodule

/* rtl/tsp_checker.sv */
// port-level checks for the utc timestamp parser, bound to the top level
// depends on tsp_pkg and iso8601_timestamp_parser
module tsp_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        in_last_char,
  input logic        out_valid,
  input logic        out_stall,
  input logic [2:0]  out_status,
  input logic [31:0] out_epoch_seconds
);

  // a held result keeps its status and epoch
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_status) &&
                               $stable(out_epoch_seconds))
    else $error("result changed while stalled");

  // no byte is taken while a result waits
  a_no_take_with_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("input open while result pending");

  // the marked byte closes the input until its result is taken
  a_last_closes: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_last_char |=> in_stall && !out_valid)
    else $error("input not closed after last byte");

  // epoch is zero on every failing status
  a_epoch_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != tsp_pkg::STAT_OK |-> out_epoch_seconds == 32'd0)
    else $error("nonzero epoch with error status");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status <= tsp_pkg::STAT_RANGE)
    else $error("undefined status code");

endmodule

bind iso8601_timestamp_parser tsp_checker u_tsp_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_valid),
  .in_stall          (in_stall),
  .in_last_char      (in_last_char),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_status        (out_status),
  .out_epoch_seconds (out_epoch_seconds)
);

/* test/tb_iso8601_timestamp_parser.sv */
// testbench for iso8601_timestamp_parser: streams utc timestamp strings one character per item
// and checks status, parsed fields and epoch seconds against an in-bench parser model
// depends on tsp_pkg and the rtl of the block
module tb_iso8601_timestamp_parser;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WatchdogLimit = 2000;
  localparam int PhaseChars = 110;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } char_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [13:0] year;
    logic [6:0]  month;
    logic [6:0]  day;
    logic [6:0]  hour;
    logic [6:0]  minute;
    logic [6:0]  second;
    logic [31:0] epoch;
  } stamp_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_character = 8'h00;
  logic        in_last_char = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  out_status;
  logic [13:0] out_year;
  logic [6:0]  out_month;
  logic [6:0]  out_day;
  logic [6:0]  out_hour;
  logic [6:0]  out_minute;
  logic [6:0]  out_second;
  logic [31:0] out_epoch_seconds;

  iso8601_timestamp_parser dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_character(in_character),
    .in_last_char(in_last_char),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_status(out_status),
    .out_year(out_year),
    .out_month(out_month),
    .out_day(out_day),
    .out_hour(out_hour),
    .out_minute(out_minute),
    .out_second(out_second),
    .out_epoch_seconds(out_epoch_seconds)
  );

  char_item_t    pending_chars[$];
  stamp_result_t expected_stamps[$];
  logic [7:0]    stamp_text[$];
  char_item_t    next_char;
  stamp_result_t got_stamp;
  stamp_result_t want_stamp;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int mismatches = 0;
  int chars_taken = 0;
  int stamps_taken = 0;
  int chars_queued = 0;
  int quiet_cycles = 0;
  int status_hits[5] = '{default: 0};

  // parser model state
  int unsigned scan_pos = 0;
  logic [13:0] acc_year = '0;
  logic [6:0]  acc_month = '0;
  logic [6:0]  acc_day = '0;
  logic [6:0]  acc_hour = '0;
  logic [6:0]  acc_minute = '0;
  logic [6:0]  acc_second = '0;
  logic [2:0]  scan_fault = tsp_pkg::STAT_OK;

  int unsigned month_start_day[12] = '{0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334};

  task automatic predict_char(input logic [7:0] ch, input logic last);
    logic [7:0] want;
    int unsigned digit;
    longint unsigned days;
    longint unsigned secs;
    stamp_result_t r;
    if (scan_pos < tsp_pkg::TsLength) begin
      case (scan_pos)
        4, 7:    want = tsp_pkg::CH_DASH;
        10:      want = tsp_pkg::CH_T;
        13, 16:  want = tsp_pkg::CH_COLON;
        19:      want = tsp_pkg::CH_Z;
        default: want = tsp_pkg::CH_NONE;
      endcase
      if (want != tsp_pkg::CH_NONE) begin
        // separator faults outrank non-digit faults
        if (ch != want) scan_fault = tsp_pkg::STAT_SEPARATOR;
      end else if (ch < tsp_pkg::CH_ZERO || ch > tsp_pkg::CH_NINE) begin
        if (scan_fault == tsp_pkg::STAT_OK) scan_fault = tsp_pkg::STAT_DIGIT;
      end else begin
        digit = ch - tsp_pkg::CH_ZERO;
        if (scan_pos <= 3) acc_year = acc_year * 10 + digit;
        else if (scan_pos <= 6) acc_month = acc_month * 10 + digit;
        else if (scan_pos <= 9) acc_day = acc_day * 10 + digit;
        else if (scan_pos <= 12) acc_hour = acc_hour * 10 + digit;
        else if (scan_pos <= 15) acc_minute = acc_minute * 10 + digit;
        else acc_second = acc_second * 10 + digit;
      end
    end
    if (scan_pos < 31) scan_pos++;
    if (!last) return;

    r.year = acc_year;
    r.month = acc_month;
    r.day = acc_day;
    r.hour = acc_hour;
    r.minute = acc_minute;
    r.second = acc_second;
    r.epoch = '0;
    if (scan_pos != tsp_pkg::TsLength) begin
      r.status = tsp_pkg::STAT_LENGTH;
    end else if (scan_fault != tsp_pkg::STAT_OK) begin
      r.status = scan_fault;
    end else if (acc_year < tsp_pkg::YEAR_MIN || acc_year > tsp_pkg::YEAR_MAX ||
                 acc_month < 7'd1 || acc_month > tsp_pkg::MONTH_MAX ||
                 acc_day < 7'd1 || acc_day > tsp_pkg::DAY_MAX ||
                 acc_hour > tsp_pkg::HOUR_MAX || acc_minute > tsp_pkg::MINSEC_MAX ||
                 acc_second > tsp_pkg::MINSEC_MAX) begin
      r.status = tsp_pkg::STAT_RANGE;
    end else begin
      // every fourth year is a leap year within 2024..2099
      days = (longint'(acc_year) - tsp_pkg::YEAR_EPOCH) * 365
             + ((longint'(acc_year) - 1) / 4 - tsp_pkg::LEAP_OFFSET)
             + month_start_day[acc_month - 1] + longint'(acc_day) - 1;
      if (acc_year % 4 == 0 && acc_month > 7'd2) days++;
      secs = days * 86400 + longint'(acc_hour) * 3600 + longint'(acc_minute) * 60
             + longint'(acc_second);
      if (secs < tsp_pkg::EPOCH_FLOOR) begin
        r.status = tsp_pkg::STAT_RANGE;
      end else begin
        r.status = tsp_pkg::STAT_OK;
        r.epoch = secs[31:0];
      end
    end
    expected_stamps.push_back(r);

    scan_pos = 0;
    acc_year = '0;
    acc_month = '0;
    acc_day = '0;
    acc_hour = '0;
    acc_minute = '0;
    acc_second = '0;
    scan_fault = tsp_pkg::STAT_OK;
  endtask

  task automatic push_number(input int unsigned value, input int digits);
    int unsigned scale;
    scale = (digits == 4) ? 1000 : 10;
    repeat (digits) begin
      stamp_text.push_back(tsp_pkg::CH_ZERO + 8'((value / scale) % 10));
      scale = scale / 10;
    end
  endtask

  task automatic build_stamp(input int unsigned y, input int unsigned mo, input int unsigned d,
                             input int unsigned h, input int unsigned mi, input int unsigned s);
    stamp_text.delete();
    push_number(y, 4);
    stamp_text.push_back(tsp_pkg::CH_DASH);
    push_number(mo, 2);
    stamp_text.push_back(tsp_pkg::CH_DASH);
    push_number(d, 2);
    stamp_text.push_back(tsp_pkg::CH_T);
    push_number(h, 2);
    stamp_text.push_back(tsp_pkg::CH_COLON);
    push_number(mi, 2);
    stamp_text.push_back(tsp_pkg::CH_COLON);
    push_number(s, 2);
    stamp_text.push_back(tsp_pkg::CH_Z);
  endtask

  task automatic commit_text();
    char_item_t item;
    foreach (stamp_text[i]) begin
      item.ch = stamp_text[i];
      item.last = (i == stamp_text.size() - 1);
      pending_chars.push_back(item);
    end
    chars_queued += stamp_text.size();
    stamp_text.delete();
  endtask

  task automatic plant_non_digit();
    int unsigned p;
    logic [7:0] b;
    do p = $urandom_range(19); while (p == 4 || p == 7 || p == 10 || p == 13 || p == 16 || p == 19);
    do b = 8'($urandom_range(255)); while (b >= tsp_pkg::CH_ZERO && b <= tsp_pkg::CH_NINE);
    stamp_text[p] = b;
  endtask

  task automatic queue_random_stamp();
    int unsigned kind;
    int unsigned y, mo, d, h, mi, s;
    int unsigned p, n;
    logic [7:0] b;
    kind = $urandom_range(99);
    y = $urandom_range(2024, 2099);
    mo = $urandom_range(1, 12);
    d = $urandom_range(1, 31);
    h = $urandom_range(0, 23);
    mi = $urandom_range(0, 59);
    s = $urandom_range(0, 59);
    if (kind >= 55 && kind < 70) begin
      case ($urandom_range(5))
        0:       y = $urandom_range(1) ? $urandom_range(2023) : $urandom_range(2100, 9999);
        1:       mo = $urandom_range(1) ? 0 : $urandom_range(13, 99);
        2:       d = $urandom_range(1) ? 0 : $urandom_range(32, 99);
        3:       h = $urandom_range(24, 99);
        4:       mi = $urandom_range(60, 99);
        default: s = $urandom_range(60, 99);
      endcase
    end
    build_stamp(y, mo, d, h, mi, s);
    if (kind >= 70 && kind < 80) begin
      case ($urandom_range(5))
        0:       p = 4;
        1:       p = 7;
        2:       p = 10;
        3:       p = 13;
        4:       p = 16;
        default: p = 19;
      endcase
      do b = 8'($urandom_range(255)); while (b == stamp_text[p]);
      stamp_text[p] = b;
      if ($urandom_range(2) == 0) plant_non_digit();
    end else if (kind >= 80 && kind < 88) begin
      plant_non_digit();
    end else if (kind >= 88 && kind < 98) begin
      if ($urandom_range(1)) begin
        n = $urandom_range(1, 19);
        while (stamp_text.size() > n) void'(stamp_text.pop_back());
      end else begin
        n = $urandom_range(1, 16);
        repeat (n) stamp_text.push_back(8'($urandom_range(255)));
      end
    end else if (kind >= 98) begin
      // raw noise of 1 to 40 bytes
      stamp_text.delete();
      n = $urandom_range(1, 40);
      repeat (n) stamp_text.push_back(8'($urandom_range(255)));
    end
    commit_text();
  endtask

  task automatic check_field(input string name, input longint unsigned want,
                             input longint unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  task automatic wait_drained();
    while (pending_chars.size() != 0 || in_valid || expected_stamps.size() != 0)
      @(negedge clk);
  endtask

  initial begin
    forever #5 clk = ~clk;
  end

  // character driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (in_valid) begin
        predict_char(in_character, in_last_char);
        chars_taken++;
      end
      if (pending_chars.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        next_char = pending_chars.pop_front();
        in_valid <= 1'b1;
        in_character <= next_char.ch;
        in_last_char <= next_char.last;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    out_stall <= (recv_stall_pct != 0) && ($urandom_range(99) < recv_stall_pct);
  end

  // result monitor
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      got_stamp = '{out_status, out_year, out_month, out_day, out_hour, out_minute, out_second,
                    out_epoch_seconds};
      if (expected_stamps.size() == 0) begin
        $display("%0t: result with nothing expected, expected none, got status %0d",
                 $time, got_stamp.status);
        mismatches++;
      end else begin
        want_stamp = expected_stamps.pop_front();
        stamps_taken++;
        if (want_stamp.status <= tsp_pkg::STAT_RANGE) status_hits[want_stamp.status]++;
        check_field("status", want_stamp.status, got_stamp.status);
        check_field("year", want_stamp.year, got_stamp.year);
        check_field("month", want_stamp.month, got_stamp.month);
        check_field("day", want_stamp.day, got_stamp.day);
        check_field("hour", want_stamp.hour, got_stamp.hour);
        check_field("minute", want_stamp.minute, got_stamp.minute);
        check_field("second", want_stamp.second, got_stamp.second);
        check_field("epoch_seconds", want_stamp.epoch, got_stamp.epoch);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WatchdogLimit) begin
      $display("%0t: no handshake for %0d cycles", $time, WatchdogLimit);
      $display("*** FAILED ***");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  int idle_plan[4] = '{0, 46, 0, 32};
  int stall_plan[4] = '{0, 0, 46, 32};

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    build_stamp(2024, 1, 1, 0, 0, 0);
    commit_text();
    build_stamp(2099, 12, 31, 23, 59, 59);
    commit_text();
    build_stamp(2024, 2, 29, 12, 34, 56);
    commit_text();
    // day past month end rolls into march
    build_stamp(2025, 2, 31, 7, 8, 9);
    commit_text();
    build_stamp(2023, 12, 31, 23, 59, 59);
    commit_text();
    build_stamp(2100, 1, 1, 0, 0, 0);
    commit_text();
    build_stamp(2030, 0, 10, 1, 1, 1);
    commit_text();
    build_stamp(2030, 13, 10, 1, 1, 1);
    commit_text();
    build_stamp(2030, 5, 0, 1, 1, 1);
    commit_text();
    build_stamp(2030, 5, 32, 1, 1, 1);
    commit_text();
    build_stamp(2030, 5, 5, 24, 59, 59);
    commit_text();
    build_stamp(2030, 5, 5, 23, 60, 0);
    commit_text();
    build_stamp(2030, 5, 5, 23, 0, 60);
    commit_text();
    build_stamp(9999, 99, 99, 99, 99, 99);
    commit_text();
    build_stamp(0, 0, 0, 0, 0, 0);
    commit_text();
    build_stamp(2040, 6, 15, 10, 20, 30);
    stamp_text[19] = "z";
    commit_text();
    build_stamp(2040, 6, 15, 10, 20, 30);
    stamp_text[1] = 8'hFF;
    commit_text();
    // non-digit before a bad separator: separator wins
    build_stamp(2040, 6, 15, 10, 20, 30);
    stamp_text[2] = tsp_pkg::CH_COLON;
    stamp_text[13] = tsp_pkg::CH_DASH;
    commit_text();
    stamp_text.push_back(8'h00);
    commit_text();
    build_stamp(2050, 7, 7, 7, 7, 7);
    void'(stamp_text.pop_back());
    commit_text();
    build_stamp(2050, 7, 7, 7, 7, 7);
    stamp_text.push_back(tsp_pkg::CH_Z);
    commit_text();
    // overlong string saturates the position counter
    build_stamp(2050, 7, 7, 7, 7, 7);
    repeat (15) stamp_text.push_back(8'($urandom_range(255)));
    commit_text();

    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = idle_plan[ph];
      recv_stall_pct = stall_plan[ph];
      chars_queued = 0;
      while (chars_queued < PhaseChars) queue_random_stamp();
      // hold the sender until every result of the phase is back
      wait_drained();
    end

    repeat (10) @(posedge clk);
    $display("sent %0d characters, checked %0d stamps over 4 pacing phases", chars_taken,
             stamps_taken);
    $display("status mix: ok %0d, length %0d, separator %0d, non-digit %0d, range %0d",
             status_hits[0], status_hits[1], status_hits[2], status_hits[3], status_hits[4]);
    if (mismatches == 0 && expected_stamps.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches, %0d results never arrived", mismatches, expected_stamps.size());
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
